@@ rtl/core/eci_pkg.sv @@
// Shared types, curve selector codes and constants of the easing-curve interpolator.
`timescale 1ns / 1ps

package eci_pkg;

   localparam int CMD_WIDTH           = 4;
   localparam int VALUE_WIDTH_DEF     = 16;
   localparam int FRACTION_BITS_DEF   = 16;

   // Curve selector codes.
   localparam logic [CMD_WIDTH-1:0] CMD_LINEAR     = 4'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_CUBIC_IN   = 4'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_CUBIC_OUT  = 4'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_CUBIC_IO   = 4'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_QUAD_IN    = 4'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_QUAD_OUT   = 4'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_QUAD_IO    = 4'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_BACK_IN    = 4'd7;
   localparam logic [CMD_WIDTH-1:0] CMD_BACK_OUT   = 4'd8;
   localparam logic [CMD_WIDTH-1:0] CMD_BACK_IO    = 4'd9;

   // Overshoot constants of the back curves as exact decimal fractions.
   localparam longint BACK_C1_NUM = 64'd170158;
   localparam longint BACK_C1_DEN = 64'd100000;
   localparam longint BACK_C2_NUM = 64'd25949095;
   localparam longint BACK_C2_DEN = 64'd10000000;

   typedef enum logic [1:0] {
      FAM_LINEAR,
      FAM_CUBIC,
      FAM_QUAD,
      FAM_BACK
   } family_type;

   typedef enum logic [1:0] {
      SHAPE_IN,
      SHAPE_OUT,
      SHAPE_INOUT
   } shape_type;

   typedef struct packed {
      family_type family;
      shape_type  shape;
   } curve_sel_type;

endpackage

@@ rtl/core/eci_fxmul.sv @@
// Signed fixed-point multiplier with round-to-nearest, ties away from zero.
`timescale 1ns / 1ps

module eci_fxmul #(
   parameter int A_WIDTH   = 18,
   parameter int B_WIDTH   = 18,
   parameter int P_WIDTH   = 18,
   parameter int FRAC_BITS = 16
) (
   input  logic signed [A_WIDTH-1:0] op_a,
   input  logic signed [B_WIDTH-1:0] op_b,
   output logic signed [P_WIDTH-1:0] prod
);

   localparam int FULL = A_WIDTH + B_WIDTH + 1;
   localparam logic signed [FULL-1:0] HALF =
      {{(FULL - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic signed [FULL-1:0] HALF_M1 = HALF - FULL'(1);

   logic signed [FULL-1:0] full;
   logic signed [FULL-1:0] biased;
   logic signed [FULL-1:0] shifted;

   // Adding half minus one to a negative product before the floor shift rounds
   // its magnitude half away from zero, same as for positive products.
   assign full    = FULL'(op_a) * FULL'(op_b);
   assign biased  = full + (full[FULL-1] ? HALF_M1 : HALF);
   assign shifted = biased >>> FRAC_BITS;
   assign prod    = shifted[P_WIDTH-1:0];

endmodule

@@ rtl/core/eci_decode.sv @@
// Curve selector decoder: splits the command into curve family and shape.
`timescale 1ns / 1ps

module eci_decode
   import eci_pkg::*;
(
   input  logic [CMD_WIDTH-1:0] cmd,
   output curve_sel_type        sel
);

   always_comb begin
      unique case (cmd)
         CMD_CUBIC_IN:  sel = '{family: FAM_CUBIC, shape: SHAPE_IN};
         CMD_CUBIC_OUT: sel = '{family: FAM_CUBIC, shape: SHAPE_OUT};
         CMD_CUBIC_IO:  sel = '{family: FAM_CUBIC, shape: SHAPE_INOUT};
         CMD_QUAD_IN:   sel = '{family: FAM_QUAD, shape: SHAPE_IN};
         CMD_QUAD_OUT:  sel = '{family: FAM_QUAD, shape: SHAPE_OUT};
         CMD_QUAD_IO:   sel = '{family: FAM_QUAD, shape: SHAPE_INOUT};
         CMD_BACK_IN:   sel = '{family: FAM_BACK, shape: SHAPE_IN};
         CMD_BACK_OUT:  sel = '{family: FAM_BACK, shape: SHAPE_OUT};
         CMD_BACK_IO:   sel = '{family: FAM_BACK, shape: SHAPE_INOUT};
         // Linear, and the unused codes, which behave as linear.
         default:       sel = '{family: FAM_LINEAR, shape: SHAPE_IN};
      endcase
   end

endmodule

@@ rtl/core/easing_curve_interpolator.sv @@
// Top level of the easing-curve interpolator: seven-stage pipelined curve evaluation and blend.
`timescale 1ns / 1ps

//  Channel  Direction  Ports                                                 Beat
//  req      in         req_valid/ready, cmd, start_value, end_value,         one item
//                      curve_position
//  rsp      out        rsp_valid/ready, eased_value                          one result
//
// Every beat on req gives exactly one beat on rsp; one beat is taken every cycle while
// rsp_ready stays high. The stages are the input stage (clamp, decode and mirror), the
// chain of three dependent rounded multiplies of the curve (square, cube, constant
// scaling), the shape select, the blend multiply and the final add, each in a stage of
// its own.
// Reset clears only the stage valid bits; the data registers hold no state worth clearing.
// A stall on rsp ripples back stage by stage: a stage loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out and req_ready falls only when all
// seven stages hold a beat.
//
// The curves are evaluated on a mirrored position x: the out curves, and the upper half of
// the in-out curves, use x = 1 - t and return 1 - g(x); everything else uses x = t. Rounding
// is symmetric, so the back in-out upper half folds into the same form as its lower half.

module easing_curve_interpolator
   import eci_pkg::*;
#(
   parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CMD_WIDTH-1:0]          req_cmd,
   input  logic signed [VALUE_WIDTH-1:0] req_start_value,
   input  logic signed [VALUE_WIDTH-1:0] req_end_value,
   input  logic [FRACTION_BITS:0]        req_curve_position,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH+1:0] rsp_eased_value
);

   localparam int NUM_STAGES = 7;
   localparam int FB  = FRACTION_BITS;
   localparam int DW  = VALUE_WIDTH + 1;   // difference end - start
   localparam int OW  = VALUE_WIDTH + 2;   // result
   localparam int XW  = FB + 2;            // position as a signed operand
   localparam int KW  = FB + 3;            // twice the position as a signed operand
   localparam int CW  = FB + 5;            // curve-domain values, about +-16.0

   // Back-curve constants rounded to nearest at the fraction width.
   localparam longint C1 = ((BACK_C1_NUM << FB) + BACK_C1_DEN / 2) / BACK_C1_DEN;
   localparam longint C2 = ((BACK_C2_NUM << FB) + BACK_C2_DEN / 2) / BACK_C2_DEN;
   localparam longint ONE = 64'd1 << FB;

   localparam logic signed [CW-1:0] C1_S    = CW'(C1);
   localparam logic signed [CW-1:0] C2_S    = CW'(C2);
   localparam logic signed [CW-1:0] C3_S    = CW'(C1 + ONE);
   localparam logic signed [CW-1:0] C2P1_S  = CW'(C2 + ONE);
   localparam logic signed [CW-1:0] ONE_C   = CW'(ONE);
   localparam logic [FB:0]          ONE_T   = {1'b1, {FB{1'b0}}};

   // ------------------------------------------------------------------
   // Flow control.
   // ------------------------------------------------------------------
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] adv;

   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_ready;
      for (int i = NUM_STAGES - 1; i >= 1; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int i = 2; i <= NUM_STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_ready = adv[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   // ------------------------------------------------------------------
   // Stage 1: saturate the position, decode the curve, pick x.
   // ------------------------------------------------------------------
   curve_sel_type          dec;
   logic [FB:0]            t_sat;
   logic                   low_half;
   logic                   mirror_in;
   logic [FB:0]            s1_x_in;
   logic signed [DW-1:0]   s1_diff_in;

   eci_decode u_decode (
      .cmd (req_cmd),
      .sel (dec)
   );

   always_comb begin
      // Positions above one are clamped to one.
      t_sat     = (req_curve_position[FB] && |req_curve_position[FB-1:0]) ? ONE_T
                  : req_curve_position;
      low_half  = (t_sat[FB:FB-1] == 2'b00);
      mirror_in = (dec.shape == SHAPE_OUT) || ((dec.shape == SHAPE_INOUT) && !low_half);
      s1_x_in   = mirror_in ? (ONE_T - t_sat) : t_sat;
      s1_diff_in = DW'(req_end_value) - DW'(req_start_value);
   end

   curve_sel_type                 s1_sel_ff;
   logic                          s1_mirror_ff;
   logic [FB:0]                   s1_x_ff;
   logic signed [VALUE_WIDTH-1:0] s1_a_ff;
   logic signed [DW-1:0]          s1_diff_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_sel_ff    <= dec;
         s1_mirror_ff <= mirror_in;
         s1_x_ff      <= s1_x_in;
         s1_a_ff      <= req_start_value;
         s1_diff_ff   <= s1_diff_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: x squared and (c2 + 1) * 2x.
   // ------------------------------------------------------------------
   logic signed [XW-1:0] s1_x_s;
   logic signed [KW-1:0] s1_x2_s;
   logic signed [CW-1:0] s2_x2_in;
   logic signed [CW-1:0] s2_kmul_in;

   assign s1_x_s  = $signed({1'b0, s1_x_ff});
   assign s1_x2_s = $signed({1'b0, s1_x_ff, 1'b0});

   eci_fxmul #(.A_WIDTH(XW), .B_WIDTH(XW), .P_WIDTH(CW), .FRAC_BITS(FB)) u_mul_sq (
      .op_a (s1_x_s),
      .op_b (s1_x_s),
      .prod (s2_x2_in)
   );

   eci_fxmul #(.A_WIDTH(CW), .B_WIDTH(KW), .P_WIDTH(CW), .FRAC_BITS(FB)) u_mul_k (
      .op_a (C2P1_S),
      .op_b (s1_x2_s),
      .prod (s2_kmul_in)
   );

   curve_sel_type                 s2_sel_ff;
   logic                          s2_mirror_ff;
   logic [FB:0]                   s2_x_ff;
   logic signed [CW-1:0]          s2_x2_ff;
   logic signed [CW-1:0]          s2_kmul_ff;
   logic signed [VALUE_WIDTH-1:0] s2_a_ff;
   logic signed [DW-1:0]          s2_diff_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_sel_ff    <= s1_sel_ff;
         s2_mirror_ff <= s1_mirror_ff;
         s2_x_ff      <= s1_x_ff;
         s2_x2_ff     <= s2_x2_in;
         s2_kmul_ff   <= s2_kmul_in;
         s2_a_ff      <= s1_a_ff;
         s2_diff_ff   <= s1_diff_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: x cubed, c1 * x^2 and the back in-out factor k.
   // ------------------------------------------------------------------
   logic signed [XW-1:0] s2_x_s;
   logic signed [CW-1:0] s3_x3_in;
   logic signed [CW-1:0] s3_c1x2_in;
   logic signed [CW-1:0] s3_k_in;

   assign s2_x_s  = $signed({1'b0, s2_x_ff});
   assign s3_k_in = s2_kmul_ff - C2_S;

   eci_fxmul #(.A_WIDTH(CW), .B_WIDTH(XW), .P_WIDTH(CW), .FRAC_BITS(FB)) u_mul_cube (
      .op_a (s2_x2_ff),
      .op_b (s2_x_s),
      .prod (s3_x3_in)
   );

   eci_fxmul #(.A_WIDTH(CW), .B_WIDTH(CW), .P_WIDTH(CW), .FRAC_BITS(FB)) u_mul_c1 (
      .op_a (C1_S),
      .op_b (s2_x2_ff),
      .prod (s3_c1x2_in)
   );

   curve_sel_type                 s3_sel_ff;
   logic                          s3_mirror_ff;
   logic [FB:0]                   s3_x_ff;
   logic signed [CW-1:0]          s3_x2_ff;
   logic signed [CW-1:0]          s3_x3_ff;
   logic signed [CW-1:0]          s3_c1x2_ff;
   logic signed [CW-1:0]          s3_k_ff;
   logic signed [VALUE_WIDTH-1:0] s3_a_ff;
   logic signed [DW-1:0]          s3_diff_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_sel_ff    <= s2_sel_ff;
         s3_mirror_ff <= s2_mirror_ff;
         s3_x_ff      <= s2_x_ff;
         s3_x2_ff     <= s2_x2_ff;
         s3_x3_ff     <= s3_x3_in;
         s3_c1x2_ff   <= s3_c1x2_in;
         s3_k_ff      <= s3_k_in;
         s3_a_ff      <= s2_a_ff;
         s3_diff_ff   <= s2_diff_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: c3 * x^3 and x^2 * k.
   // ------------------------------------------------------------------
   logic signed [CW-1:0] s4_c3x3_in;
   logic signed [CW-1:0] s4_bk_in;

   eci_fxmul #(.A_WIDTH(CW), .B_WIDTH(CW), .P_WIDTH(CW), .FRAC_BITS(FB)) u_mul_c3 (
      .op_a (C3_S),
      .op_b (s3_x3_ff),
      .prod (s4_c3x3_in)
   );

   eci_fxmul #(.A_WIDTH(CW), .B_WIDTH(CW), .P_WIDTH(CW), .FRAC_BITS(FB)) u_mul_bk (
      .op_a (s3_x2_ff),
      .op_b (s3_k_ff),
      .prod (s4_bk_in)
   );

   curve_sel_type                 s4_sel_ff;
   logic                          s4_mirror_ff;
   logic [FB:0]                   s4_x_ff;
   logic signed [CW-1:0]          s4_x2_ff;
   logic signed [CW-1:0]          s4_x3_ff;
   logic signed [CW-1:0]          s4_c1x2_ff;
   logic signed [CW-1:0]          s4_c3x3_ff;
   logic signed [CW-1:0]          s4_bk_ff;
   logic signed [VALUE_WIDTH-1:0] s4_a_ff;
   logic signed [DW-1:0]          s4_diff_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_sel_ff    <= s3_sel_ff;
         s4_mirror_ff <= s3_mirror_ff;
         s4_x_ff      <= s3_x_ff;
         s4_x2_ff     <= s3_x2_ff;
         s4_x3_ff     <= s3_x3_ff;
         s4_c1x2_ff   <= s3_c1x2_ff;
         s4_c3x3_ff   <= s4_c3x3_in;
         s4_bk_ff     <= s4_bk_in;
         s4_a_ff      <= s3_a_ff;
         s4_diff_ff   <= s3_diff_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: select the curve shape and undo the mirroring.
   // ------------------------------------------------------------------
   logic signed [CW-1:0] shape_val;
   logic signed [CW-1:0] s5_curve_in;

   always_comb begin
      unique case (s4_sel_ff.family)
         FAM_CUBIC: begin
            shape_val = (s4_sel_ff.shape == SHAPE_INOUT) ? (s4_x3_ff <<< 2) : s4_x3_ff;
         end
         FAM_QUAD: begin
            shape_val = (s4_sel_ff.shape == SHAPE_INOUT) ? (s4_x2_ff <<< 1) : s4_x2_ff;
         end
         FAM_BACK: begin
            shape_val = (s4_sel_ff.shape == SHAPE_INOUT) ? (s4_bk_ff <<< 1)
                        : (s4_c3x3_ff - s4_c1x2_ff);
         end
         default: begin
            shape_val = $signed({{(CW-FB-1){1'b0}}, s4_x_ff});
         end
      endcase
      s5_curve_in = s4_mirror_ff ? (ONE_C - shape_val) : shape_val;
   end

   logic signed [CW-1:0]          s5_curve_ff;
   logic signed [VALUE_WIDTH-1:0] s5_a_ff;
   logic signed [DW-1:0]          s5_diff_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_curve_ff <= s5_curve_in;
         s5_a_ff     <= s4_a_ff;
         s5_diff_ff  <= s4_diff_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: scale the difference by the curve.
   // ------------------------------------------------------------------
   logic signed [OW-1:0] s6_scaled_in;

   eci_fxmul #(.A_WIDTH(DW), .B_WIDTH(CW), .P_WIDTH(OW), .FRAC_BITS(FB)) u_mul_blend (
      .op_a (s5_diff_ff),
      .op_b (s5_curve_ff),
      .prod (s6_scaled_in)
   );

   logic signed [OW-1:0]          s6_scaled_ff;
   logic signed [VALUE_WIDTH-1:0] s6_a_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_scaled_ff <= s6_scaled_in;
         s6_a_ff      <= s5_a_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: add the start value; this is the output register.
   // ------------------------------------------------------------------
   logic signed [OW-1:0] eased_in;
   logic signed [OW-1:0] eased_ff;

   assign eased_in = OW'(s6_a_ff) + s6_scaled_ff;

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         eased_ff <= eased_in;
      end
   end

   assign rsp_eased_value = eased_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[1])
      else $error("accepted beat did not reach stage 1");

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input blocked while the pipeline has a bubble");

   a_stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[6] && !adv[6]) |=> (valid_ff[6] && $stable(s6_scaled_ff)))
      else $error("stalled blend stage lost or changed its beat");

   a_linear_curve: assert property (@(posedge clock) disable iff (reset)
      (adv[5] && valid_ff[4] && s4_sel_ff.family == FAM_LINEAR) |=>
      (s5_curve_ff == $signed({{(CW-FB-1){1'b0}}, $past(s4_x_ff)})))
      else $error("linear curve does not equal the position");

endmodule

@@ dv/tb_easing_curve_interpolator.sv @@
// Self-checking testbench of the easing-curve interpolator: bursty stimulus, stalls, predictor.
`timescale 1ns / 1ps

module tb_easing_curve_interpolator;
   import eci_pkg::*;

   localparam int VW         = VALUE_WIDTH_DEF;
   localparam int FB         = FRACTION_BITS_DEF;
   localparam int OW         = VW + 2;
   localparam int POS_ONE    = 1 << FB;
   localparam int POS_HALF   = 1 << (FB - 1);
   localparam int POS_MAX    = (1 << (FB + 1)) - 1;
   localparam int VALUE_MAX  = (1 << (VW - 1)) - 1;
   localparam int VALUE_MIN  = -(1 << (VW - 1));

   // The back-curve overshoot constants, rounded to nearest at the fraction width.
   localparam longint OVERSHOOT_C1 = ((BACK_C1_NUM << FB) + BACK_C1_DEN / 2) / BACK_C1_DEN;
   localparam longint OVERSHOOT_C2 = ((BACK_C2_NUM << FB) + BACK_C2_DEN / 2) / BACK_C2_DEN;
   localparam longint OVERSHOOT_C3 = OVERSHOOT_C1 + POS_ONE;

   // Selector codes that the block does not define; they must behave as linear.
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_FIRST = CMD_BACK_IO + 1'b1;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_LAST  = '1;

   localparam int RANDOM_ITEMS = 1030;
   localparam int HOLD_TRIGGER = 300;   // accepted beats before the long receiver hold-off
   localparam int HOLD_CYCLES  = 80;    // far longer than the seven-stage pipe can absorb
   localparam int DRAIN_CYCLES = 20;    // tail wait after the last result
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct {
      logic [CMD_WIDTH-1:0]   cmd;
      logic signed [VW-1:0]   origin;
      logic signed [VW-1:0]   target;
      logic [FB:0]            pos;
   } ease_item_type;

   typedef struct {
      ease_item_type          item;
      logic signed [OW-1:0]   value;
   } eased_entry_type;

   typedef enum int {
      FLOW_OPEN,
      FLOW_COIN,
      FLOW_PERIODIC,
      FLOW_SPARSE
   } flow_mode_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CMD_WIDTH-1:0]   req_cmd = CMD_LINEAR;
   logic signed [VW-1:0]   req_start_value = '0;
   logic signed [VW-1:0]   req_end_value = '0;
   logic [FB:0]            req_curve_position = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic signed [OW-1:0]   rsp_eased_value;

   ease_item_type    req_backlog[$];      // items waiting to be offered on req
   eased_entry_type  pending_eased[$];    // predicted results of accepted beats, oldest first

   logic          req_fired = 1'b0;    // a req beat was taken at the last rising edge
   int            accepted_reqs = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   easing_curve_interpolator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_start_value    (req_start_value),
      .req_end_value      (req_end_value),
      .req_curve_position (req_curve_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_eased_value    (rsp_eased_value)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Fixed-point product a*b scaled down by one unit, rounded to nearest with ties
   // away from zero.
   function automatic longint scaled_product(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) begin
         return (p + POS_HALF) >>> FB;
      end
      return -((-p + POS_HALF) >>> FB);
   endfunction

   // Curve value at position t, in fraction units. The out curves and the upper half of
   // the in-out curves are built from the mirrored position u = 1 - t.
   function automatic longint curve_fraction(logic [CMD_WIDTH-1:0] sel, longint t);
      longint u, t2, u2, t3, u3, k, shaped;
      bit     lower;
      u     = POS_ONE - t;
      t2    = scaled_product(t, t);
      u2    = scaled_product(u, u);
      t3    = scaled_product(t2, t);
      u3    = scaled_product(u2, u);
      lower = t < POS_HALF;
      case (sel)
         CMD_CUBIC_IN:  shaped = t3;
         CMD_CUBIC_OUT: shaped = POS_ONE - u3;
         CMD_CUBIC_IO:  shaped = lower ? 4 * t3 : POS_ONE - 4 * u3;
         CMD_QUAD_IN:   shaped = t2;
         CMD_QUAD_OUT:  shaped = POS_ONE - u2;
         CMD_QUAD_IO:   shaped = lower ? 2 * t2 : POS_ONE - 2 * u2;
         CMD_BACK_IN:   shaped = scaled_product(OVERSHOOT_C3, t3)
                                 - scaled_product(OVERSHOOT_C1, t2);
         CMD_BACK_OUT:  shaped = POS_ONE - scaled_product(OVERSHOOT_C3, u3)
                                 + scaled_product(OVERSHOOT_C1, u2);
         CMD_BACK_IO: begin
            if (lower) begin
               k      = scaled_product(OVERSHOOT_C2 + POS_ONE, 2 * t) - OVERSHOOT_C2;
               shaped = 2 * scaled_product(t2, k);
            end else begin
               k      = OVERSHOOT_C2 - scaled_product(OVERSHOOT_C2 + POS_ONE, 2 * u);
               shaped = POS_ONE + 2 * scaled_product(u2, k);
            end
         end
         default:       shaped = t;
      endcase
      return shaped;
   endfunction

   // Expected eased value of one item; positions above one saturate to one.
   function automatic logic signed [OW-1:0] eased_value_of(ease_item_type it);
      longint a, b, t, r;
      a = it.origin;
      b = it.target;
      t = it.pos;
      if (t > POS_ONE) begin
         t = POS_ONE;
      end
      r = a + scaled_product(b - a, curve_fraction(it.cmd, t));
      return r[OW-1:0];
   endfunction

   function automatic void add_item(logic [CMD_WIDTH-1:0] cmd, int origin, int target,
                                    int pos);
      ease_item_type it;
      it.cmd    = cmd;
      it.origin = origin[VW-1:0];
      it.target = target[VW-1:0];
      it.pos    = pos[FB:0];
      req_backlog.push_back(it);
   endfunction

   // Prints one line per failure and counts every one.
   task automatic note_failure(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Watchdog: a hung or starved block ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_eased.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Monitor. Both channels are sampled at the rising edge. The result beat is checked
   // before the request beat of the same edge is recorded, so the order of the two
   // channels within one edge never matters.
   always @(posedge clock) begin
      eased_entry_type entry;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (pending_eased.size() == 0) begin
               note_failure($sformatf("result %0d with no beat outstanding", rsp_eased_value));
            end else begin
               entry = pending_eased.pop_front();
               if (rsp_eased_value !== entry.value) begin
                  note_failure($sformatf(
                     "cmd %0d start %0d end %0d pos %0d: eased_value %0d, expected %0d",
                     entry.item.cmd, entry.item.origin, entry.item.target, entry.item.pos,
                     rsp_eased_value, entry.value));
               end
            end
         end
         if (req_valid && req_ready) begin
            entry.item.cmd    = req_cmd;
            entry.item.origin = req_start_value;
            entry.item.target = req_end_value;
            entry.item.pos    = req_curve_position;
            entry.value       = eased_value_of(entry.item);
            pending_eased.push_back(entry);
            accepted_reqs++;
         end
      end
   end

   // Driver. Items go out in bursts of random length separated by random gaps; about a
   // quarter of the gaps are empty, which gives long back-to-back stretches. A beat that
   // has not been taken yet is held with its payload untouched.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      ease_item_type it;
      if (!reset && !(req_valid && !req_fired)) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         if (burst_left > 0 && req_backlog.size() > 0) begin
            it = req_backlog.pop_front();
            req_cmd            <= it.cmd;
            req_start_value    <= it.origin;
            req_end_value      <= it.target;
            req_curve_position <= it.pos;
            req_valid          <= 1'b1;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            if (burst_left == 0 && gap_left > 0) begin
               gap_left--;
            end
         end
      end
   end

   // Receiver. It runs a stall pattern for a random stretch, then picks another: always
   // ready, a coin toss, a fixed one-in-three stall, or a rare stall. Once, after a few
   // hundred beats, it holds off long enough for every stage to fill and req_ready to fall
   // while the driver keeps offering.
   flow_mode_type flow_mode = FLOW_OPEN;
   int            pattern_left = 0;
   int            hold_left = 0;
   bit            hold_done = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_reqs >= HOLD_TRIGGER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               flow_mode    = flow_mode_type'($urandom_range(FLOW_OPEN, FLOW_SPARSE));
               pattern_left = $urandom_range(16, 128);
            end
            pattern_left--;
            case (flow_mode)
               FLOW_OPEN:     rsp_ready <= 1'b1;
               FLOW_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               FLOW_PERIODIC: rsp_ready <= (pattern_left % 3) != 0;
               default:       rsp_ready <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   initial begin
      int sel, pick, origin, target, pos;

      // Directed part: every curve across the full value range, the saturating position,
      // both sides of the in-out split point, the unused selectors and worst overshoot.
      for (int c = CMD_LINEAR; c <= CMD_BACK_IO; c++) begin
         add_item(c[CMD_WIDTH-1:0], VALUE_MIN, VALUE_MAX, POS_HALF / 2 + POS_HALF / 4);
      end
      add_item(CMD_SPARE_FIRST, 100, -200, 40000);
      add_item(CMD_SPARE_LAST, VALUE_MAX, VALUE_MIN, POS_HALF + 1);
      add_item(CMD_BACK_IO, VALUE_MAX, VALUE_MIN, POS_HALF - 1);
      add_item(CMD_BACK_IO, VALUE_MAX, VALUE_MIN, POS_HALF);
      add_item(CMD_CUBIC_IO, VALUE_MIN, VALUE_MAX, POS_HALF - 1);
      add_item(CMD_QUAD_IO, VALUE_MIN, VALUE_MAX, POS_HALF);
      add_item(CMD_LINEAR, VALUE_MIN, VALUE_MAX, 0);
      add_item(CMD_BACK_OUT, VALUE_MIN, VALUE_MAX, POS_ONE);
      add_item(CMD_BACK_IN, VALUE_MAX, VALUE_MIN, POS_MAX);
      add_item(CMD_QUAD_OUT, VALUE_MIN, VALUE_MAX, POS_ONE + 1);
      add_item(CMD_BACK_IN, VALUE_MAX, VALUE_MIN, POS_ONE / 4);
      add_item(CMD_BACK_OUT, VALUE_MIN, VALUE_MAX, POS_ONE - POS_ONE / 4);
      add_item(CMD_BACK_IO, 0, 0, POS_HALF / 3);

      // Random part: mostly defined curves with positions in range, some spare selectors,
      // saturating positions, split points and extreme values.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, CMD_SPARE_LAST)
                                           : $urandom_range(CMD_LINEAR, CMD_BACK_IO);
         pick   = $urandom_range(0, 9);
         origin = (pick == 0) ? VALUE_MIN : (pick == 1) ? VALUE_MAX : $urandom;
         pick   = $urandom_range(0, 9);
         target = (pick == 0) ? VALUE_MIN : (pick == 1) ? VALUE_MAX : $urandom;
         case ($urandom_range(0, 15))
            0:       pos = 0;
            1:       pos = POS_ONE;
            2:       pos = $urandom_range(POS_ONE + 1, POS_MAX);
            3:       pos = POS_HALF - $urandom_range(0, 1);
            default: pos = $urandom_range(0, POS_ONE);
         endcase
         add_item(sel[CMD_WIDTH-1:0], origin, target, pos);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every item offered and taken, then every prediction matched, then a short tail
      // to catch any stray result.
      while (req_backlog.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (pending_eased.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
